// ===== sv/hvt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvt_pkg
// Types, widths and arithmetic helpers of the homogeneous vertex transform.
// ----------------------------------------------------------------------------
package hvt_pkg;

	localparam int W  = 32;
	localparam int F  = 16;
	localparam int NW = W + F;
	localparam int PW = 2 * W;
	localparam int SW = 2 * W + 2;

	typedef enum logic [2:0] {
		KIND_LOAD  = 3'd0,
		KIND_PROJ  = 3'd1,
		KIND_AFF   = 3'd2,
		KIND_SCALE = 3'd3,
		KIND_TRANS = 3'd4
	} kind_t;

	typedef logic signed [W-1:0] word_t;

	localparam word_t ONE_FX  = W'(64'sd1 <<< F);
	localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);
	localparam word_t WMAX = {1'b0, {(W-1){1'b1}}};
	localparam word_t WMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [NW-1:0] QHALF = NW'(1) << (W - 1);

	typedef struct packed {
		word_t val;
		logic  clip;
	} sat_t;

	typedef struct packed {
		logic [W-1:0]  rem;
		logic [NW-1:0] num;
		logic [NW-1:0] q;
	} lane_t;

	typedef struct packed {
		lane_t        lx;
		lane_t        ly;
		logic [W-1:0] den;
		logic         negx;
		logic         negy;
		word_t        x;
		word_t        y;
		word_t        z;
		logic         proj;
		logic         fault;
		logic         clip;
	} div_t;

	function automatic sat_t sat_sum(input logic signed [SW-1:0] s);
		logic signed [SW-1:0] sh;
		sat_t r;
		sh = s >>> F;
		if (sh > SMAX) begin
			r.val = WMAX;
			r.clip = 1'b1;
		end else if (sh < SMIN) begin
			r.val = WMIN;
			r.clip = 1'b1;
		end else begin
			r.val = sh[W-1:0];
			r.clip = 1'b0;
		end
		return r;
	endfunction

	function automatic sat_t sat_quot(input logic [NW-1:0] q, input logic neg);
		logic [NW-1:0] nq;
		sat_t r;
		nq = ~q + NW'(1);
		if (neg) begin
			if (q > QHALF) begin
				r.val = WMIN;
				r.clip = 1'b1;
			end else begin
				r.val = nq[W-1:0];
				r.clip = 1'b0;
			end
		end else begin
			if (q > QHALF - NW'(1)) begin
				r.val = WMAX;
				r.clip = 1'b1;
			end else begin
				r.val = q[W-1:0];
				r.clip = 1'b0;
			end
		end
		return r;
	endfunction

	function automatic lane_t div_step(input lane_t a, input logic [W-1:0] d);
		logic [W:0] r2;
		logic [W:0] diff;
		lane_t r;
		r2 = {a.rem, a.num[NW-1]};
		diff = r2 - {1'b0, d};
		r.num = a.num << 1;
		if (r2 >= {1'b0, d}) begin
			r.rem = diff[W-1:0];
			r.q = {a.q[NW-2:0], 1'b1};
		end else begin
			r.rem = r2[W-1:0];
			r.q = {a.q[NW-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic div_t div_next(input div_t a);
		div_t r;
		r = a;
		r.lx = div_step(a.lx, a.den);
		r.ly = div_step(a.ly, a.den);
		return r;
	endfunction

	function automatic logic [W-1:0] mag(input word_t v);
		return v[W-1] ? (~v + W'(1)) : v;
	endfunction

endpackage

// ===== sv/homogeneous_vertex_transform.sv =====
`timescale 1ns / 1ps
// Throughput: one word per cycle while the output is not stalled;
// the 48-step restoring divider is fully pipelined.
// Load words and unused kinds give no result; a load takes effect for the next word.
// A stall at the output holds every stage.
// Reset: asynchronous, clears all valid bits and sets the matrix to identity.
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform
// 4x4 Q16.16 point transform: products, row sums, saturation, divide by w if projective.
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         kind,
	input  logic [3:0]         elem_index,
	input  hvt_pkg::word_t     elem_value,
	input  hvt_pkg::word_t     point_x,
	input  hvt_pkg::word_t     point_y,
	input  hvt_pkg::word_t     point_z,
	output logic               out_valid,
	input  logic               out_ready,
	output hvt_pkg::word_t     out_x,
	output hvt_pkg::word_t     out_y,
	output hvt_pkg::word_t     out_z,
	output logic               divide_fault,
	output logic               saturated
);
	import hvt_pkg::*;

	logic en;
	logic acc;
	word_t m_q [16];
	word_t p [3];

	logic signed [PW-1:0] prod_c [4][3];
	logic signed [PW-1:0] prod_s1 [4][3];
	word_t tr_s1 [4];
	logic v_s1, proj_s1;

	logic signed [SW-1:0] sum_s2 [4];
	logic v_s2, proj_s2;

	sat_t r_s3 [4];
	logic v_s3, proj_s3;

	div_t div_s [NW+1];
	logic dv_s [NW+1];
	div_t d0;

	sat_t qx, qy;

	assign en = !out_valid || out_ready;
	assign in_ready = en;
	assign acc = in_valid && in_ready;
	assign p[0] = point_x;
	assign p[1] = point_y;
	assign p[2] = point_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				m_q[i] <= (i % 5 == 0) ? ONE_FX : '0;
			end
		end else if (acc && kind == KIND_LOAD) begin
			m_q[elem_index] <= elem_value;
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 3; c++) begin
				case (kind)
					KIND_PROJ, KIND_AFF: prod_c[r][c] = PW'(m_q[r*4+c]) * PW'(p[c]);
					KIND_SCALE: prod_c[r][c] = (r == c) ? PW'(m_q[r*4+c]) * PW'(p[c]) : '0;
					KIND_TRANS: prod_c[r][c] = (r == c) ? (PW'(p[c]) <<< F) : '0;
					default: prod_c[r][c] = '0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc && (kind == KIND_PROJ || kind == KIND_AFF
				|| kind == KIND_SCALE || kind == KIND_TRANS);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_c;
			for (int r = 0; r < 4; r++) begin
				tr_s1[r] <= m_q[r*4+3];
				sum_s2[r] <= SW'(prod_s1[r][0]) + SW'(prod_s1[r][1]) + SW'(prod_s1[r][2])
					+ (SW'(tr_s1[r]) <<< F);
				r_s3[r] <= sat_sum(sum_s2[r]);
			end
			proj_s1 <= (kind == KIND_PROJ);
			proj_s2 <= proj_s1;
			proj_s3 <= proj_s2;
		end
	end

	always_comb begin
		d0.x = r_s3[0].val;
		d0.y = r_s3[1].val;
		d0.z = r_s3[2].val;
		d0.proj = proj_s3;
		d0.fault = proj_s3 && (r_s3[3].val == '0);
		d0.clip = r_s3[0].clip || r_s3[1].clip || r_s3[2].clip
			|| (proj_s3 && r_s3[3].clip);
		d0.negx = r_s3[0].val[W-1] ^ r_s3[3].val[W-1];
		d0.negy = r_s3[1].val[W-1] ^ r_s3[3].val[W-1];
		d0.den = mag(r_s3[3].val);
		d0.lx.rem = '0;
		d0.lx.q = '0;
		d0.lx.num = {mag(r_s3[0].val), {F{1'b0}}};
		d0.ly.rem = '0;
		d0.ly.q = '0;
		d0.ly.num = {mag(r_s3[1].val), {F{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s[0] <= 1'b0;
		end else if (en) begin
			dv_s[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0] <= d0;
		end
	end

	for (genvar k = 0; k < NW; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_s[k+1] <= dv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k+1] <= div_next(div_s[k]);
			end
		end
	end

	assign qx = sat_quot(div_s[NW].lx.q, div_s[NW].negx);
	assign qy = sat_quot(div_s[NW].ly.q, div_s[NW].negy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_s[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_z <= div_s[NW].z;
			if (!div_s[NW].proj) begin
				out_x <= div_s[NW].x;
				out_y <= div_s[NW].y;
				divide_fault <= 1'b0;
				saturated <= div_s[NW].clip;
			end else if (div_s[NW].fault) begin
				out_x <= '0;
				out_y <= '0;
				divide_fault <= 1'b1;
				saturated <= div_s[NW].clip;
			end else begin
				out_x <= qx.val;
				out_y <= qy.val;
				divide_fault <= 1'b0;
				saturated <= div_s[NW].clip || qx.clip || qy.clip;
			end
		end
	end

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && divide_fault) |-> (out_x == '0 && out_y == '0))
		else $error("fault word with nonzero x or y");

	a_load_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && kind == KIND_LOAD) |=> !v_s1)
		else $error("load word entered the pipeline");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(v_s1) && $stable(v_s3) && $stable(dv_s[NW])))
		else $error("pipeline moved during a stall");

endmodule

// ===== dv/hvt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvt_checker
// Watches both channels of the vertex transform, keeps its own copy of the
// matrix, predicts each transform result and compares it field by field.
// ----------------------------------------------------------------------------
module hvt_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  logic [2:0]     kind,
	input  logic [3:0]     elem_index,
	input  hvt_pkg::word_t elem_value,
	input  hvt_pkg::word_t point_x,
	input  hvt_pkg::word_t point_y,
	input  hvt_pkg::word_t point_z,
	input  logic           out_valid,
	input  logic           out_ready,
	input  hvt_pkg::word_t out_x,
	input  hvt_pkg::word_t out_y,
	input  hvt_pkg::word_t out_z,
	input  logic           divide_fault,
	input  logic           saturated,
	output int             fail_count,
	output int             pending,
	output int             checked
);
	import hvt_pkg::*;

	typedef logic signed [79:0] wide_t;

	typedef struct packed {
		word_t v;
		logic  c;
	} fit_t;

	typedef struct packed {
		word_t x;
		word_t y;
		word_t z;
		logic  fault;
		logic  sat;
	} vertex_t;

	word_t   mat [16];
	vertex_t vertex_q [$];

	function automatic fit_t fit(input wide_t s);
		fit_t r;
		r.c = 1'b0;
		r.v = s[31:0];
		if (s > wide_t'(WMAX)) begin
			r.v = WMAX;
			r.c = 1'b1;
		end else if (s < wide_t'(WMIN)) begin
			r.v = WMIN;
			r.c = 1'b1;
		end
		return r;
	endfunction

	function automatic fit_t row_dot(input int row, input word_t px, input word_t py,
		input word_t pz);
		wide_t s;
		s = wide_t'(mat[row*4]) * wide_t'(px) + wide_t'(mat[row*4+1]) * wide_t'(py)
			+ wide_t'(mat[row*4+2]) * wide_t'(pz) + wide_t'(mat[row*4+3]) * 80'sd65536;
		return fit(s >>> 16);
	endfunction

	function automatic fit_t diag_dot(input int row, input word_t p);
		wide_t s;
		s = wide_t'(mat[row*5]) * wide_t'(p) + wide_t'(mat[row*4+3]) * 80'sd65536;
		return fit(s >>> 16);
	endfunction

	function automatic fit_t quotient(input word_t num, input word_t den);
		logic [79:0] n;
		logic [79:0] d;
		logic [79:0] q;
		fit_t r;
		n = (num[31] ? 80'(-wide_t'(num)) : 80'(num)) << 16;
		d = den[31] ? 80'(-wide_t'(den)) : 80'(den);
		q = n / d;
		r.c = 1'b0;
		if (num[31] != den[31]) begin
			if (q > 80'h8000_0000) begin
				r.v = WMIN;
				r.c = 1'b1;
			end else
				r.v = word_t'(-q);
		end else if (q > 80'h7fff_ffff) begin
			r.v = WMAX;
			r.c = 1'b1;
		end else
			r.v = q[31:0];
		return r;
	endfunction

	function automatic vertex_t transform(input logic [2:0] k, input word_t px,
		input word_t py, input word_t pz);
		fit_t fx, fy, fz, fw;
		vertex_t e;
		e.fault = 1'b0;
		if (k == KIND_PROJ || k == KIND_AFF) begin
			fx = row_dot(0, px, py, pz);
			fy = row_dot(1, px, py, pz);
			fz = row_dot(2, px, py, pz);
			e.sat = fx.c | fy.c | fz.c;
			if (k == KIND_PROJ) begin
				fw = row_dot(3, px, py, pz);
				e.sat |= fw.c;
				if (fw.v == 0) begin
					e.fault = 1'b1;
					fx.v = '0;
					fy.v = '0;
				end else begin
					fx = quotient(fx.v, fw.v);
					fy = quotient(fy.v, fw.v);
					e.sat |= fx.c | fy.c;
				end
			end
		end else if (k == KIND_SCALE) begin
			fx = diag_dot(0, px);
			fy = diag_dot(1, py);
			fz = diag_dot(2, pz);
			e.sat = fx.c | fy.c | fz.c;
		end else begin
			fx = fit(wide_t'(px) + wide_t'(mat[3]));
			fy = fit(wide_t'(py) + wide_t'(mat[7]));
			fz = fit(wide_t'(pz) + wide_t'(mat[11]));
			e.sat = fx.c | fy.c | fz.c;
		end
		e.x = fx.v;
		e.y = fy.v;
		e.z = fz.v;
		return e;
	endfunction

	task automatic report(input string field, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		fail_count++;
		$display("%0t ns: %s mismatch, expected %h, actual %h", $realtime, field,
			exp_v, act_v);
	endtask

	initial begin
		fail_count = 0;
		checked = 0;
	end

	assign pending = vertex_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				mat[i] <= (i % 5 == 0) ? ONE_FX : '0;
			vertex_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (vertex_q.size() == 0) begin
					fail_count++;
					$display("%0t ns: result word, expected none, actual %h %h %h",
						$realtime, out_x, out_y, out_z);
				end else begin
					vertex_t e;
					e = vertex_q.pop_front();
					checked++;
					if (out_x !== e.x) report("out_x", e.x, out_x);
					if (out_y !== e.y) report("out_y", e.y, out_y);
					if (out_z !== e.z) report("out_z", e.z, out_z);
					if (divide_fault !== e.fault)
						report("divide_fault", 32'(e.fault), 32'(divide_fault));
					if (saturated !== e.sat)
						report("saturated", 32'(e.sat), 32'(saturated));
				end
			end
			if (in_valid && in_ready) begin
				if (kind == KIND_LOAD)
					mat[elem_index] <= elem_value;
				else if (kind <= KIND_TRANS)
					vertex_q.push_back(transform(kind, point_x, point_y, point_z));
			end
		end
	end

endmodule

// ===== dv/homogeneous_vertex_transform_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_test
// Drives matrix loads and point transforms of every kind, directed corners
// first and then random words under three idling patterns; the checker
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform_test;
	import hvt_pkg::*;

	localparam int LIMIT = 400000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [2:0] kind;
	logic [3:0] elem_index;
	word_t      elem_value;
	word_t      point_x;
	word_t      point_y;
	word_t      point_z;
	logic       out_valid;
	logic       out_ready;
	word_t      out_x;
	word_t      out_y;
	word_t      out_z;
	logic       divide_fault;
	logic       saturated;
	int         fail_count;
	int         pending;
	int         checked;
	int         cycles;
	int         send_idle;
	int         recv_idle;
	int         words_sent;

	homogeneous_vertex_transform u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .elem_index(elem_index), .elem_value(elem_value),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_ready(out_ready), .out_x(out_x), .out_y(out_y),
		.out_z(out_z), .divide_fault(divide_fault), .saturated(saturated)
	);

	hvt_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .elem_index(elem_index), .elem_value(elem_value),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_ready(out_ready), .out_x(out_x), .out_y(out_y),
		.out_z(out_z), .divide_fault(divide_fault), .saturated(saturated),
		.fail_count(fail_count), .pending(pending), .checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("homogeneous_vertex_transform regression: fail");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	function automatic word_t pick_value();
		case ($urandom_range(0, 5))
			0: return word_t'($urandom());
			1: return word_t'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
			2: begin
				case ($urandom_range(0, 3))
					0: return WMAX;
					1: return WMIN;
					2: return '0;
					default: return ONE_FX;
				endcase
			end
			3: return word_t'($signed($urandom_range(0, 32'h3ffffff)) - 32'sh1ffffff);
			default: return ($urandom_range(0, 1) ? ONE_FX : -ONE_FX)
				+ word_t'($signed($urandom_range(0, 32'h8000)) - 32'sh4000);
		endcase
	endfunction

	task automatic send(input logic [2:0] k, input logic [3:0] idx, input word_t v,
		input word_t px, input word_t py, input word_t pz);
		if ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		elem_index <= idx;
		elem_value <= v;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic load(input int idx, input word_t v);
		send(KIND_LOAD, idx[3:0], v, word_t'($urandom()), word_t'($urandom()),
			word_t'($urandom()));
	endtask

	task automatic point(input logic [2:0] k, input word_t px, input word_t py,
		input word_t pz);
		send(k, 4'($urandom()), word_t'($urandom()), px, py, pz);
	endtask

	task automatic random_words(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 25)
				load($urandom_range(0, 15), pick_value());
			else if (r < 95)
				point(3'($urandom_range(KIND_PROJ, KIND_TRANS)), pick_value(),
					pick_value(), pick_value());
			else
				point(3'($urandom_range(5, 7)), pick_value(), pick_value(), pick_value());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_LOAD;
		elem_index = '0;
		elem_value = '0;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		send_idle = 6;
		recv_idle = 80;
		words_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		point(KIND_PROJ, ONE_FX, 2 * ONE_FX, 3 * ONE_FX);
		point(KIND_AFF, WMAX, WMIN, '0);
		point(KIND_SCALE, WMIN, WMAX, -ONE_FX);
		point(KIND_TRANS, WMAX, WMIN, ONE_FX);
		point(3'd5, ONE_FX, ONE_FX, ONE_FX);
		point(3'd6, WMAX, WMAX, WMAX);
		point(3'd7, WMIN, WMIN, WMIN);
		load(3, WMAX);
		load(7, WMIN);
		load(11, ONE_FX);
		point(KIND_TRANS, WMAX, WMIN, ONE_FX);
		point(KIND_SCALE, ONE_FX, -ONE_FX, WMAX);
		point(KIND_AFF, '0, '0, '0);
		load(15, '0);
		point(KIND_PROJ, ONE_FX, ONE_FX, ONE_FX);
		load(15, -ONE_FX);
		point(KIND_PROJ, 5 * ONE_FX, -3 * ONE_FX, 7 * ONE_FX);
		load(3, '0);
		load(7, '0);
		load(11, '0);
		load(15, 32'sd1);
		point(KIND_PROJ, WMAX, WMIN, ONE_FX);
		load(0, WMAX);
		load(5, WMIN);
		point(KIND_AFF, WMAX, WMAX, WMIN);

		random_words(540);
		send_idle = 80;
		recv_idle = 6;
		random_words(540);
		send_idle = 0;
		recv_idle = 0;
		random_words(545);
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("sent %0d words of all kinds under three idling patterns", words_sent);
		$display("compared %0d result words, %0d mismatches", checked, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("homogeneous_vertex_transform regression: pass");
		else
			$display("homogeneous_vertex_transform regression: fail");
		$finish;
	end

endmodule
